/* src/joint_pd_servo_with_jog_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the joint servo block
// Concurrent checks sampled on clk, quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef JOINT_PD_SERVO_WITH_JOG_UNIT_DEFINES_SVH
`define JOINT_PD_SERVO_WITH_JOG_UNIT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define JPSJ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define JPSJ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/jpsj_pkg.sv */
// ---------------------------------------------------------------------------
// jpsj_pkg
// Widths, register codes, fixed-point constants, gain tables and rounding
// helpers for the joint servo.
// ---------------------------------------------------------------------------
package jpsj_pkg;

	localparam int JOINT_COUNT_DEF = 6;
	localparam int TABLE_JOINTS    = 6;

	localparam int JIDX_W   = 3;
	localparam int JEXT_W   = 4;   // joint index widened to cover up to 16 joints
	localparam int POS_W    = 32;
	localparam int STICK_W  = 16;
	localparam int BTN_W    = 6;
	localparam int CMD_W    = 32;
	localparam int S_DATA_W = 56;  // 54 payload bits rounded up to bytes
	localparam int M_DATA_W = 32;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 24;
	localparam int MODE_W = 2;
	localparam int INV_W  = 24;
	localparam int MASK_W = 6;

	localparam int GAIN_W    = 27;
	localparam int DELTA_W   = 12;
	localparam int STICK_D_W = 8;
	localparam int MUL_A_W   = 34;
	localparam int MUL_B_W   = 28;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int TERM_W    = 44;
	localparam int VT_W      = 28;

	localparam logic [CFG_AW-1:0] REG_DRIVE_MODE     = 2'd0;
	localparam logic [CFG_AW-1:0] REG_GAIN_SET       = 2'd1;
	localparam logic [CFG_AW-1:0] REG_INVERSE_STEP   = 2'd2;
	localparam logic [CFG_AW-1:0] REG_PRISMATIC_MASK = 2'd3;

	localparam logic [MODE_W-1:0] MODE_TORQUE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POSITION = 2'd2;

	localparam logic [INV_W-1:0] INV_STEP_RST = 24'd256000;

	localparam logic signed [DELTA_W-1:0] JOG_STEP    = 12'sd524;   // 0.0005 in Q12.20
	localparam logic signed [DELTA_W-1:0] STICK_STEP  = 12'sd210;   // 0.0002 in Q12.20
	localparam logic signed [POS_W-1:0]   UPPER_LIMIT = 32'sd838860; // 0.8 in Q12.20
	localparam logic signed [MUL_B_W-1:0] VEL_GAIN    = 28'sd19661; // 0.3 in Q16.16

	// Saturate to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Arithmetic right shift, rounding half toward plus infinity.
	function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] x,
	                                               input int unsigned sh);
		logic signed [63:0] half;
		half = 64'sd1 <<< (sh - 1);
		return (x + half) >>> sh;
	endfunction

	// Proportional gain, Q16.16; joints without a table entry get zero.
	function automatic logic [GAIN_W-1:0] kp_of(input logic gs, input logic [JIDX_W-1:0] j);
		case (j)
			3'd0, 3'd1: return gs ? 27'd6553600 : 27'd65536000;
			3'd2:       return gs ? 27'd655360  : 27'd39321600;
			3'd3:       return gs ? 27'd196608  : 27'd131072;
			3'd4, 3'd5: return gs ? 27'd196608  : 27'd98304;
			default:    return '0;
		endcase
	endfunction

	// Derivative gain, Q16.16.
	function automatic logic [GAIN_W-1:0] kd_of(input logic gs, input logic [JIDX_W-1:0] j);
		case (j)
			3'd0, 3'd1:       return gs ? 27'd655360  : 27'd6553600;
			3'd2:             return gs ? 27'd393216  : 27'd3932160;
			3'd3, 3'd4, 3'd5: return gs ? 27'd1966080 : 27'd9830;
			default:          return '0;
		endcase
	endfunction

endpackage

/* src/joint_pd_servo_with_jog_unit.sv */
// ---------------------------------------------------------------------------
// joint_pd_servo_with_jog_unit
// Per-joint PD servo with button and stick jog; target and last position
// kept in on-chip memories, one shared multiplier for all servo-loop products.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake                      Payload
// cfg       in   cfg_wen (no back-pressure)     cfg_addr, cfg_wdata
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser joint, tdata sample
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser joint, tdata command
//
// Steps per sample: torque mode READ, ERR, T1-T4, FIN; velocity mode READ,
// ERR, V1-V3, FIN; position and unused mode READ, ERR, FIN; the steps follow
// the passes through the single multiplier (three for torque, two for velocity)
// plus the memory read. An index at or above JOINT_COUNT is dropped, no result.
// Reset clears the seeded flags (flip-flops); the memories need no clearing
// pass since an unseeded joint ignores what they hold.
// A stalled result waits in the output register; the next sample is taken
// meanwhile and only its final step waits for the register to free up.
// ---------------------------------------------------------------------------
`include "joint_pd_servo_with_jog_unit_defines.svh"

module joint_pd_servo_with_jog_unit
	import jpsj_pkg::*;
#(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_wen,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CFG_DW-1:0]   cfg_wdata,

	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// [31:0] measured_position, [47:32] stick_axis, [53:48] jog_buttons, [55:54] zero
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// [2:0] joint_index
	input  logic [JIDX_W-1:0]   s_axis_tuser,

	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [31:0] drive_command
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// [2:0] out_joint
	output logic [JIDX_W-1:0]   m_axis_tuser
);

	localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_READ = 11'b000_0000_0010,
		S_ERR  = 11'b000_0000_0100,
		S_T1   = 11'b000_0000_1000,
		S_T2   = 11'b000_0001_0000,
		S_T3   = 11'b000_0010_0000,
		S_T4   = 11'b000_0100_0000,
		S_V1   = 11'b000_1000_0000,
		S_V2   = 11'b001_0000_0000,
		S_V3   = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [MODE_W-1:0] mode_q;
	logic              gain_q;
	logic [INV_W-1:0]  inv_q;
	logic [MASK_W-1:0] mask_q;

	// latched sample
	logic [JIDX_W-1:0]        j_q;
	logic [AW-1:0]            addr_q;
	logic signed [POS_W-1:0]  q_q;
	logic signed [STICK_W-1:0] s_q;
	logic [BTN_W-1:0]         btn_q;

	// joint state
	logic signed [POS_W-1:0] tgt_mem [JOINT_COUNT];
	logic signed [POS_W-1:0] prv_mem [JOINT_COUNT];
	logic signed [POS_W-1:0] tgt_rd_q;
	logic signed [POS_W-1:0] prv_rd_q;
	logic [JOINT_COUNT-1:0]  seeded_q;

	// datapath registers
	logic signed [POS_W-1:0]   tgt_new_q;
	logic signed [POS_W:0]     diff_q;
	logic signed [POS_W:0]     err_q;
	logic signed [POS_W-1:0]   dq_q;
	logic signed [TERM_W-1:0]  pterm_q;
	logic signed [TERM_W-1:0]  dterm_q;
	logic signed [VT_W-1:0]    vt_q;
	logic signed [PROD_W-1:0]  prod_q;

	// output register
	logic              out_valid_q;
	logic [JIDX_W-1:0] out_joint_q;
	logic [CMD_W-1:0]  out_cmd_q;

	logic              in_xfer;
	logic              in_ok;
	logic [JEXT_W-1:0] jext;
	logic [AW-1:0]     acc_addr;
	logic              out_load;
	logic              seeded_cur;
	logic              wr_prv;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign jext          = {1'b0, s_axis_tuser};
	assign acc_addr      = jext[AW-1:0];
	assign in_ok         = (32'(s_axis_tuser) < JOINT_COUNT);
	assign seeded_cur    = seeded_q[addr_q];
	// seeding writes the last position in every mode; afterwards only torque does
	assign wr_prv        = (mode_q == MODE_TORQUE) || !seeded_cur;
	assign out_load      = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_cmd_q;
	assign m_axis_tuser  = out_joint_q;

	// -----------------------------------------------------------------------
	// Target delta: wrist jog, dead-banded stick and range push-back
	// -----------------------------------------------------------------------
	logic signed [STICK_W:0]     s_ext;
	logic [STICK_W:0]            s_abs;
	logic [19:0]                 s_x5;
	logic [24:0]                 s_scaled;
	logic [STICK_D_W-1:0]        s_step;
	logic                        jog_up;
	logic                        jog_dn;
	logic                        prism;
	logic [7:0]                  mask_ext;
	logic signed [DELTA_W-1:0]   delta;
	logic signed [POS_W-1:0]     tgt_base;
	logic signed [POS_W-1:0]     prv_base;
	logic [POS_W-1:0]            tgt_sat;

	always_comb begin
		s_ext    = 17'(s_q);
		s_abs    = s_ext[STICK_W] ? 17'(-s_ext) : 17'(s_ext);
		s_x5     = 20'(s_abs) * 20'd5;
		// magnitude * 210, rounded half up after dropping 15 bits
		s_scaled = 25'(s_abs) * 25'd210 + 25'd16384;
		s_step   = s_scaled[22:15];

		jog_up = 1'b0;
		jog_dn = 1'b0;
		case (j_q)
			3'd3: begin
				jog_up = btn_q[0];
				jog_dn = btn_q[1];
			end
			3'd4: begin
				jog_up = btn_q[2];
				jog_dn = btn_q[3];
			end
			3'd5: begin
				jog_up = btn_q[4];
				jog_dn = btn_q[5];
			end
			default: begin
				jog_up = 1'b0;
				jog_dn = 1'b0;
			end
		endcase

		mask_ext = {2'b00, mask_q};
		prism    = (32'(j_q) < TABLE_JOINTS) && mask_ext[j_q];

		delta = '0;
		if (jog_up) delta = delta + JOG_STEP;
		if (jog_dn) delta = delta - JOG_STEP;
		if (prism) begin
			// stick counts only outside the one-fifth dead band
			if (s_x5 >= 20'd32768) begin
				if (s_ext[STICK_W]) begin
					delta = delta - $signed({{(DELTA_W-STICK_D_W){1'b0}}, s_step});
				end else begin
					delta = delta + $signed({{(DELTA_W-STICK_D_W){1'b0}}, s_step});
				end
			end
			if (q_q > UPPER_LIMIT) delta = delta - STICK_STEP;
			if (q_q < 0)           delta = delta + STICK_STEP;
		end

		// first sample of a joint stands in for the stored values
		tgt_base = seeded_cur ? tgt_rd_q : q_q;
		prv_base = seeded_cur ? prv_rd_q : q_q;
		tgt_sat  = sat32(64'(tgt_base) + 64'(delta));
	end

	// -----------------------------------------------------------------------
	// Shared multiplier: operand select per step, product registered
	// -----------------------------------------------------------------------
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic                      mul_en;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (state_q)
			S_T1: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = $signed({{(MUL_B_W-INV_W){1'b0}}, inv_q});
			end
			S_T2: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, kp_of(gain_q, j_q)});
			end
			S_T3: begin
				mul_a = MUL_A_W'(dq_q);
				mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, kd_of(gain_q, j_q)});
			end
			S_V1: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = VEL_GAIN;
			end
			S_V3: begin
				mul_a = MUL_A_W'(vt_q);
				mul_b = $signed({{(MUL_B_W-INV_W){1'b0}}, inv_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// -----------------------------------------------------------------------
	// Final command per drive mode
	// -----------------------------------------------------------------------
	logic [CMD_W-1:0] cmd;

	always_comb begin
		case (mode_q)
			MODE_TORQUE:   cmd = sat32(64'(pterm_q) - 64'(dterm_q));
			MODE_VELOCITY: cmd = sat32(shr_rnd(64'(prod_q), 8));
			MODE_POSITION: cmd = CMD_W'(shr_rnd(64'(tgt_new_q), 4));
			default:       cmd = '0;
		endcase
	end

	// -----------------------------------------------------------------------
	// Sequencer, configuration, seeded flags and output valid
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_TORQUE;
			gain_q      <= 1'b0;
			inv_q       <= INV_STEP_RST;
			mask_q      <= '0;
			seeded_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_addr)
					REG_DRIVE_MODE:     mode_q <= cfg_wdata[MODE_W-1:0];
					REG_GAIN_SET:       gain_q <= cfg_wdata[0];
					REG_INVERSE_STEP:   inv_q  <= cfg_wdata[INV_W-1:0];
					REG_PRISMATIC_MASK: mask_q <= cfg_wdata[MASK_W-1:0];
					default: ;
				endcase
			end

			// hold the result until the downstream side takes it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					// drop samples for joints that do not exist
					if (in_xfer && in_ok) state_q <= S_READ;
				end
				S_READ: state_q <= S_ERR;
				S_ERR: begin
					seeded_q[addr_q] <= 1'b1;
					case (mode_q)
						MODE_TORQUE:   state_q <= S_T1;
						MODE_VELOCITY: state_q <= S_V1;
						default:       state_q <= S_FIN;
					endcase
				end
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_T4;
				S_T4: state_q <= S_FIN;
				S_V1: state_q <= S_V2;
				S_V2: state_q <= S_V3;
				S_V3: state_q <= S_FIN;
				S_FIN: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Joint memories: read on transfer, write back after the target update
	// -----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tgt_rd_q <= tgt_mem[acc_addr];
			prv_rd_q <= prv_mem[acc_addr];
		end
		if (state_q == S_ERR) begin
			tgt_mem[addr_q] <= tgt_new_q;
			if (wr_prv) prv_mem[addr_q] <= q_q;
		end
	end

	// -----------------------------------------------------------------------
	// Datapath registers
	// -----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			j_q    <= s_axis_tuser;
			addr_q <= acc_addr;
			q_q    <= $signed(s_axis_tdata[31:0]);
			s_q    <= $signed(s_axis_tdata[47:32]);
			btn_q  <= s_axis_tdata[53:48];
		end

		if (mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end

		unique case (state_q)
			S_READ: begin
				tgt_new_q <= $signed(tgt_sat);
				diff_q    <= 33'(q_q) - 33'(prv_base);
			end
			S_ERR: begin
				err_q <= 33'(tgt_new_q) - 33'(q_q);
			end
			S_T2: begin
				// speed from the position step times the inverse step
				dq_q <= $signed(sat32(shr_rnd(64'(prod_q), 12)));
			end
			S_T3: begin
				pterm_q <= TERM_W'(shr_rnd(64'(prod_q), 20));
			end
			S_T4: begin
				dterm_q <= TERM_W'(shr_rnd(64'(prod_q), 16));
			end
			S_V2: begin
				vt_q <= VT_W'(shr_rnd(64'(prod_q), 20));
			end
			default: ;
		endcase

		if (out_load) begin
			out_joint_q <= j_q;
			out_cmd_q   <= cmd;
		end
	end

	// -----------------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------------
	`JPSJ_ASSERT_NXT(a_valid_joint_reads, in_xfer && in_ok, state_q == S_READ, "valid joint sample did not start a memory read")
	`JPSJ_ASSERT_NXT(a_bad_joint_dropped, in_xfer && !in_ok, state_q == S_IDLE && seeded_q == $past(seeded_q), "out-of-range joint sample changed state")
	`JPSJ_ASSERT_NXT(a_seed_after_update, state_q == S_ERR, seeded_q[$past(addr_q)], "joint not marked seeded after its update")
	`JPSJ_ASSERT_NXT(a_result_loaded, out_load, m_axis_tvalid && m_axis_tuser == $past(j_q) && state_q == S_IDLE, "finished result not presented for its joint")

endmodule
